FILE: sv/pfisc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// PCM sample converter package
// Opcodes, widths and scale constants shared by the converter modules.
// ----------------------------------------------------------------------------
package pfisc_pkg;

  localparam int OpWidth     = 2;
  localparam int SampleWidth = 32;
  localparam int S24Shift    = 8;

  typedef enum logic [OpWidth-1:0] {
    OP_S16_TO_F32 = 2'd0,
    OP_F32_TO_S24 = 2'd1,
    OP_F32_TO_S16 = 2'd2,
    OP_UNUSED     = 2'd3
  } op_t;

  // Scale values as normalized 24-bit mantissas with the hidden bit set:
  // 8388607 = 0xfffffe * 2^-1 (exponent 22), 32767 = 0xfffe00 * 2^-9
  // (exponent 14).
  localparam logic [23:0] Scale24 = 24'hfffffe;
  localparam logic [23:0] Scale16 = 24'hfffe00;
  localparam logic [24:0] Lim24   = 25'd8388607;
  localparam logic [24:0] Lim16   = 25'd32767;

  typedef struct packed {
    op_t                    op;
    logic [SampleWidth-1:0] bits;
  } item_t;

endpackage : pfisc_pkg
`default_nettype wire

FILE: sv/pfisc_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one payload per item with a source and a sink side.
// ----------------------------------------------------------------------------
interface pfisc_stream_if #(
  parameter int Width = 32
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface : pfisc_stream_if
`default_nettype wire

FILE: sv/pfisc_s16_to_float.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s16 to float
// Exact conversion of a signed 16-bit sample to single times 1/32768.
// ----------------------------------------------------------------------------
module pfisc_s16_to_float
  import pfisc_pkg::*;
(
  input  wire logic [15:0] sample,
  output logic      [31:0] result
);
  logic        sgn;
  logic [15:0] mag;
  logic [3:0]  msb;
  logic [15:0] norm;
  logic [7:0]  expo;

  always_comb begin
    sgn  = sample[15];
    mag  = sgn ? (16'd0 - sample) : sample;
    msb  = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (mag[i]) msb = 4'(i);
    end
    norm = mag << (4'd15 - msb);
    // Value is mag * 2^-15, so exponent is msb - 15 + 127.
    expo = 8'd112 + {4'd0, msb};
    if (mag == 16'd0) result = 32'd0;
    else              result = {sgn, expo, norm[14:0], 8'd0};
  end
endmodule : pfisc_s16_to_float
`default_nettype wire

FILE: sv/pfisc_float_to_int.sv
`default_nettype none
// ----------------------------------------------------------------------------
// float to clamped integer
// Scales a single by the limit with single rounding, clamps (NaN to the
// negative limit) and rounds half to even.
// ----------------------------------------------------------------------------
module pfisc_float_to_int
  import pfisc_pkg::*;
(
  input  wire logic [31:0] x,
  input  wire logic        wide,
  output logic      [24:0] value
);
  logic        sgn;
  logic [7:0]  e;
  logic [23:0] m;
  logic [23:0] sc;
  logic [24:0] lim;
  logic [47:0] prod;
  logic        top;
  logic [23:0] pm;
  logic        rb, st;
  logic [24:0] pmr;
  int          pe;
  logic [23:0] ym;
  int          ye;
  logic        big;
  logic [24:0] ip;
  logic        h, s2;
  logic [47:0] frac;
  logic [24:0] mag;
  int          sh;

  always_comb begin
    sgn  = x[31];
    e    = x[30:23];
    m    = (e == 8'd0) ? {1'b0, x[22:0]} : {1'b1, x[22:0]};
    sc   = wide ? Scale24 : Scale16;
    lim  = wide ? Lim24 : Lim16;
    prod = m * sc;
    top  = prod[47];
    // Normalize the product of 24-bit mantissas and round to 24 bits.
    pm   = top ? prod[47:24] : prod[46:23];
    rb   = top ? prod[23] : prod[22];
    st   = top ? (|prod[22:0]) : (|prod[21:0]);
    pmr  = {1'b0, pm} + {24'd0, rb & (st | pm[0])};
    pe   = (e == 8'd0) ? -126 : (int'(e) - 127);
    pe   = pe + (wide ? 22 : 14) + (top ? 1 : 0);
    if (pmr[24]) begin
      ym = pmr[24:1];
      pe = pe + 1;
    end else begin
      ym = pmr[23:0];
    end
    ye   = pe - 23;
    // Lower exponents of nonzero products stay far below one.
    big  = (e == 8'hff) || (ye > 0) || (ym == 24'd0 ? 1'b0 : (pe >= 24));
    ip   = 25'd0;
    h    = 1'b0;
    s2   = 1'b0;
    frac = 48'd0;
    sh   = 0;
    if (ye >= 0) begin
      ip = {1'b0, ym};
    end else if (ye > -25) begin
      sh   = -ye;
      frac = {ym, 24'd0} >> sh;
      ip   = {1'b0, frac[47:24]};
      h    = frac[23];
      s2   = |frac[22:0];
    end else if (ye == -25) begin
      h  = 1'b0;
      s2 = ym != 24'd0;
    end else begin
      s2 = ym != 24'd0;
    end
    mag = ip + {24'd0, h & (s2 | ip[0])};
    if (e == 8'hff && x[22:0] != 23'd0) value = 25'd0 - lim;
    else if (big || mag > lim)           value = sgn ? (25'd0 - lim) : lim;
    else                                 value = sgn ? (25'd0 - mag) : mag;
  end
endmodule : pfisc_float_to_int
`default_nettype wire

FILE: sv/pcm_float_int_sample_converter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// PCM float/int sample converter core
// Pipeline: an accepted item is held in the input register, and its result is then registered in the result register.
// Throughput: one item per cycle while the output accepts; the input register and the result
// register each advance whenever the next stage is free.
// Reset: synchronous on rst, clears the valid flags; the data registers are not reset.
// ----------------------------------------------------------------------------
module pcm_float_int_sample_converter_core
  import pfisc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  pfisc_stream_if.sink   in_ch,
  pfisc_stream_if.source out_ch
);
  item_t       item;
  logic        item_valid;
  logic [31:0] result;
  logic        result_valid;
  logic        adv;
  logic [31:0] f_res;
  logic [24:0] i_val;
  logic [31:0] result_next;

  assign adv          = !result_valid || out_ch.ready;
  assign in_ch.ready  = !item_valid || adv;
  assign out_ch.valid = result_valid;
  assign out_ch.data  = result;

  pfisc_s16_to_float u_s2f (.sample(item.bits[15:0]), .result(f_res));
  pfisc_float_to_int u_f2i (
    .x(item.bits), .wide(item.op == OP_F32_TO_S24), .value(i_val)
  );

  always_comb begin
    unique case (item.op)
      OP_S16_TO_F32: result_next = f_res;
      OP_F32_TO_S24: result_next = {i_val[23:0], 8'd0};
      OP_F32_TO_S16: result_next = {{7{i_val[24]}}, i_val};
      default:       result_next = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (in_ch.ready) item_valid <= in_ch.valid;
      if (adv)         result_valid <= item_valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      item.op   <= op_t'(in_ch.data[33:32]);
      item.bits <= in_ch.data[31:0];
    end
    if (adv && item_valid) result <= result_next;
  end
endmodule : pcm_float_int_sample_converter_core
`default_nettype wire

FILE: bench/tb_pcm_float_int_sample_converter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the PCM float/int sample converter core
// Streams directed and random samples through every conversion, predicts
// each converted sample with exact integer arithmetic and checks the results
// in order under random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_pcm_float_int_sample_converter_core;
  import pfisc_pkg::*;

  localparam int WatchdogLimit = 2000;

  class conv_scoreboard;
    logic [31:0] pending_q[$];
    int          mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Signed 16-bit sample times 2^-15, encoded as a single.
    static function logic [31:0] s16_to_single(logic [15:0] raw);
      logic [15:0] mag;
      int          msb;
      logic [31:0] mant;
      if (raw == 16'd0) return 32'd0;
      mag = raw[15] ? (~raw + 16'd1) : raw;
      msb = 0;
      for (int i = 0; i < 16; i++) if (mag[i]) msb = i;
      mant = (32'(mag) << (23 - msb)) & 32'h7fffff;
      return {raw[15], 8'(msb + 112), mant[22:0]};
    endfunction

    // Single times lim with one single rounding, clamped, then rounded to an
    // integer with ties to even.  NaN goes to the negative limit.
    static function logic [31:0] single_to_int(logic [31:0] x, longint unsigned lim);
      longint unsigned m, p, q, ip, fr, half;
      longint          t;
      int              e, nb, sh, k;
      if (x[30:23] == 8'hff) begin
        t = (x[22:0] != 0 || x[31]) ? -longint'(lim) : longint'(lim);
        return t[31:0];
      end
      if (x[30:23] == 8'h00) begin
        m = x[22:0];
        e = -149;
      end else begin
        m = {1'b1, x[22:0]};
        e = int'(x[30:23]) - 150;
      end
      p = m * lim;
      if (p == 0) begin
        ip = 0;
      end else begin
        nb = 0;
        for (q = p; q != 0; q = q >> 1) nb++;
        q = p;
        if (nb > 24) begin
          sh = nb - 24;
          q = p >> sh;
          fr = p & ((64'd1 << sh) - 1);
          half = 64'd1 << (sh - 1);
          if (fr > half || (fr == half && q[0])) q++;
          e += sh;
        end
        if (e >= 0) begin
          if (e >= 25) ip = lim;
          else begin
            ip = q << e;
            if (ip > lim) ip = lim;
          end
        end else begin
          k = -e;
          if (k >= 40) ip = 0;
          else begin
            ip = q >> k;
            fr = q & ((64'd1 << k) - 1);
            half = 64'd1 << (k - 1);
            if (ip >= lim) ip = lim;
            else if (fr > half || (fr == half && ip[0])) ip++;
          end
        end
      end
      t = x[31] ? -longint'(ip) : longint'(ip);
      return t[31:0];
    endfunction

    function void note_sample(op_t op, logic [31:0] bits);
      logic [31:0] r;
      case (op)
        OP_S16_TO_F32: r = s16_to_single(bits[15:0]);
        OP_F32_TO_S24: r = single_to_int(bits, 64'(Lim24)) << S24Shift;
        OP_F32_TO_S16: r = single_to_int(bits, 64'(Lim16));
        default:       r = 32'd0;
      endcase
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %08h", got);
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result_bits mismatch: expected %08h, got %08h", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  pfisc_stream_if #(.Width($bits(item_t))) in_if ();
  pfisc_stream_if #(.Width(SampleWidth))   out_if ();

  pcm_float_int_sample_converter_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  conv_scoreboard sb = new();
  int tx_idle_pct = 14;
  int rx_idle_pct = 56;
  int hold_left   = 0;
  int quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data  = '0;
    out_if.ready = 1'b0;
  end

  // Result side: check, then choose ready for the next cycle.
  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready) sb.check_result(out_if.data);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("** pcm_float_int_sample_converter_core: FAILED **");
      $finish;
    end
  end

  task automatic send_sample(op_t op, logic [31:0] bits);
    item_t it;
    it.op = op;
    it.bits = bits;
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    sb.note_sample(op, bits);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic send_random(int count);
    logic [31:0] bits;
    op_t         op;
    for (int i = 0; i < count; i++) begin
      op = op_t'($urandom_range(3));
      case ($urandom_range(3))
        0: bits = $urandom;
        // Mostly floats near full scale, where rounding and clamping happen.
        default: bits = {1'($urandom_range(1)), 8'($urandom_range(135, 100)),
                         23'($urandom)};
      endcase
      send_sample(op, bits);
      if (i == 100 && tx_idle_pct == 0) hold_left = 80;
    end
  endtask

  initial begin
    logic [31:0] s16_cases[5] = '{32'h0, 32'h7fff, 32'h8000, 32'hffff, 32'habcd8001};
    logic [31:0] flt_cases[16] = '{32'h00000000, 32'h80000000, 32'h3f800000, 32'hbf800000,
                                   32'h7f800000, 32'hff800000, 32'h7fc00000, 32'hffffffff,
                                   32'h00000001, 32'h807fffff, 32'h7f7fffff, 32'hff7fffff,
                                   32'h3f000000, 32'hbf000000, 32'h3f7fffff, 32'h38000000};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (s16_cases[i]) send_sample(OP_S16_TO_F32, s16_cases[i]);
    for (int i = 0; i < 8; i++) begin
      send_sample(OP_F32_TO_S24, flt_cases[2*i]);
      send_sample(OP_F32_TO_S16, flt_cases[2*i+1]);
    end
    send_sample(OP_F32_TO_S24, 32'h3f7fffff);
    send_sample(OP_UNUSED, 32'h12345678);

    send_random(560);
    tx_idle_pct = 56;
    rx_idle_pct = 14;
    send_random(560);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random(560);
    in_if.valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("** pcm_float_int_sample_converter_core: PASSED **");
    end else begin
      $display("** pcm_float_int_sample_converter_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/pfisc_pkg.sv
sv/pfisc_stream_if.sv
sv/pfisc_s16_to_float.sv
sv/pfisc_float_to_int.sv
sv/pcm_float_int_sample_converter_core.sv
bench/tb_pcm_float_int_sample_converter_core.sv
